FILE: sv/tlcd_pkg.sv
// Shared types, command codes and constants of the TFT LCD bus controller.
package tlcd_pkg;

    // Bus command codes (low byte of a command word)
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
    localparam logic [7:0] CMD_ACCESS    = 8'h36;

    // Pixel formats; any other code behaves as serial8
    localparam logic [2:0] FMT_PACKED16 = 3'd0;
    localparam logic [2:0] FMT_WHOLE16  = 3'd1;
    localparam logic [2:0] FMT_PACKED18 = 3'd2;
    localparam logic [2:0] FMT_WHOLE18  = 3'd3;

    // Rotation codes in quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_ROTATION     = 2'd1;
    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd3;

    // Color masks
    localparam logic [7:0] MASK_TOP5 = 8'hF8;
    localparam logic [7:0] MASK_TOP6 = 8'hFC;
    localparam logic [7:0] MASK_GMID = 8'h1C;

    localparam logic [10:0] RESET_WIDTH  = 11'd240;
    localparam logic [10:0] RESET_HEIGHT = 11'd320;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [1:0]  rotation;
        logic [10:0] panel_width;
        logic [10:0] panel_height;
    } tlcd_cfg_t;

    // One in-panel pixel, already mirrored, waiting for index calculation
    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } tlcd_pix_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tlcd_qstat_t;

endpackage

FILE: sv/tlcd_front.sv
// Front end: bus word decode, window and access registers, pixel unpack and pointer advance.
module tlcd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlcd_pkg::tlcd_cfg_t    cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [17:0]            s_bus_data,
    input  tlcd_pkg::tlcd_qstat_t  qstat,
    output logic                   q_push,
    output tlcd_pkg::tlcd_pix_t    q_entry
);
    import tlcd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_COL_SH = 4'd1,
        PH_COL_SL = 4'd2,
        PH_COL_LH = 4'd3,
        PH_COL_LL = 4'd4,
        PH_ROW_SH = 4'd5,
        PH_ROW_SL = 4'd6,
        PH_ROW_LH = 4'd7,
        PH_ROW_LL = 4'd8,
        PH_PIX0   = 4'd9,
        PH_PIX1   = 4'd10,
        PH_PIX2   = 4'd11,
        PH_ACCESS = 4'd12
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] col_start_reg, col_start_next;
    logic [15:0] col_last_reg, col_last_next;
    logic [15:0] col_pos_reg, col_pos_next;
    logic [15:0] row_start_reg, row_start_next;
    logic [15:0] row_last_reg, row_last_next;
    logic [15:0] row_pos_reg, row_pos_next;
    logic [2:0]  access_reg, access_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;

    logic        accept;
    logic [7:0]  b;
    logic        emit;
    logic [7:0]  blue;
    logic [15:0] col_inc, row_inc, col_adv, row_adv;
    logic        col_wrap, row_wrap;
    logic        in_panel;
    logic [10:0] x_mir, y_mir;

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;
    assign b       = s_bus_data[7:0];

    assign col_inc  = col_pos_reg + 16'd1;
    assign row_inc  = row_pos_reg + 16'd1;
    assign col_wrap = col_inc > col_last_reg;
    assign row_wrap = row_inc > row_last_reg;
    assign col_adv  = col_wrap ? col_start_reg : col_inc;
    assign row_adv  = row_wrap ? row_start_reg : row_inc;

    assign in_panel = ({5'b0, cfg.panel_width} > col_pos_reg)
                   && ({5'b0, cfg.panel_height} > row_pos_reg);
    assign x_mir = access_reg[1] ? cfg.panel_width - 11'd1 - col_pos_reg[10:0]
                                 : col_pos_reg[10:0];
    assign y_mir = access_reg[2] ? cfg.panel_height - 11'd1 - row_pos_reg[10:0]
                                 : row_pos_reg[10:0];

    always_comb begin
        phase_next     = phase_reg;
        col_start_next = col_start_reg;
        col_last_next  = col_last_reg;
        col_pos_next   = col_pos_reg;
        row_start_next = row_start_reg;
        row_last_next  = row_last_reg;
        row_pos_next   = row_pos_reg;
        access_next    = access_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        emit           = 1'b0;
        blue           = '0;

        if (accept) begin
            if (s_cmd) begin
                case (b)
                    CMD_COL_SET: phase_next = PH_COL_SH;
                    CMD_ROW_SET: phase_next = PH_ROW_SH;
                    CMD_ACCESS:  phase_next = PH_ACCESS;
                    CMD_MEM_WRITE: begin
                        phase_next   = PH_PIX0;
                        col_pos_next = col_start_reg;
                        row_pos_next = row_start_reg;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end else begin
                case (phase_reg)
                    PH_COL_SH: begin
                        col_start_next = {b, col_start_reg[7:0]};
                        phase_next     = PH_COL_SL;
                    end
                    PH_COL_SL: begin
                        col_start_next = {col_start_reg[15:8], b};
                        phase_next     = PH_COL_LH;
                    end
                    PH_COL_LH: begin
                        col_last_next = {b, col_last_reg[7:0]};
                        phase_next    = PH_COL_LL;
                    end
                    PH_COL_LL: begin
                        col_last_next = {col_last_reg[15:8], b};
                        phase_next    = PH_IDLE;
                    end
                    PH_ROW_SH: begin
                        row_start_next = {b, row_start_reg[7:0]};
                        phase_next     = PH_ROW_SL;
                    end
                    PH_ROW_SL: begin
                        row_start_next = {row_start_reg[15:8], b};
                        phase_next     = PH_ROW_LH;
                    end
                    PH_ROW_LH: begin
                        row_last_next = {b, row_last_reg[7:0]};
                        phase_next    = PH_ROW_LL;
                    end
                    PH_ROW_LL: begin
                        row_last_next = {row_last_reg[15:8], b};
                        phase_next    = PH_IDLE;
                    end
                    PH_ACCESS: begin
                        access_next = b[7:5];
                        phase_next  = PH_IDLE;
                    end
                    PH_PIX0: begin
                        case (cfg.pixel_format)
                            FMT_PACKED16: begin
                                red_next   = b & MASK_TOP5;
                                green_next = {s_bus_data[2:0], 5'b0};
                                phase_next = PH_PIX1;
                            end
                            FMT_WHOLE16: begin
                                red_next   = {s_bus_data[16:12], 3'b0};
                                green_next = {s_bus_data[10:5], 2'b0};
                                blue       = {s_bus_data[4:0], 3'b0};
                                emit       = 1'b1;
                            end
                            FMT_PACKED18: begin
                                red_next   = {s_bus_data[8:3], 2'b0};
                                green_next = {s_bus_data[2:0], 5'b0};
                                phase_next = PH_PIX1;
                            end
                            FMT_WHOLE18: begin
                                red_next   = {s_bus_data[17:12], 2'b0};
                                green_next = {s_bus_data[11:6], 2'b0};
                                blue       = {s_bus_data[5:0], 2'b0};
                                emit       = 1'b1;
                            end
                            default: begin
                                red_next   = b & MASK_TOP5;
                                phase_next = PH_PIX1;
                            end
                        endcase
                    end
                    PH_PIX1: begin
                        case (cfg.pixel_format)
                            FMT_PACKED16: begin
                                green_next = green_reg | ({3'b0, s_bus_data[7:3]} & MASK_GMID);
                                blue       = {s_bus_data[4:0], 3'b0};
                                emit       = 1'b1;
                            end
                            FMT_PACKED18: begin
                                green_next = green_reg | ({4'b0, s_bus_data[7:4]} & MASK_GMID)
                                           | {3'b0, s_bus_data[8], 4'b0};
                                blue       = {s_bus_data[5:0], 2'b0};
                                emit       = 1'b1;
                            end
                            default: begin
                                green_next = b & MASK_TOP5;
                                phase_next = PH_PIX2;
                            end
                        endcase
                    end
                    PH_PIX2: begin
                        blue = b & MASK_TOP6;
                        emit = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        // Step the window pointer; MV moves the row first
        if (emit) begin
            phase_next = PH_PIX0;
            if (access_reg[0]) begin
                row_pos_next = row_adv;
                if (row_wrap) begin
                    col_pos_next = col_adv;
                end
            end else begin
                col_pos_next = col_adv;
                if (col_wrap) begin
                    row_pos_next = row_adv;
                end
            end
        end
    end

    assign q_push        = emit && in_panel;
    assign q_entry.x     = x_mir;
    assign q_entry.y     = y_mir;
    assign q_entry.red   = red_next;
    assign q_entry.green = green_next;
    assign q_entry.blue  = blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            col_start_reg <= '0;
            col_last_reg  <= {5'b0, RESET_WIDTH} - 16'd1;
            col_pos_reg   <= '0;
            row_start_reg <= '0;
            row_last_reg  <= {5'b0, RESET_HEIGHT} - 16'd1;
            row_pos_reg   <= '0;
            access_reg    <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            col_start_reg <= col_start_next;
            col_last_reg  <= col_last_next;
            col_pos_reg   <= col_pos_next;
            row_start_reg <= row_start_next;
            row_last_reg  <= row_last_next;
            row_pos_reg   <= row_pos_next;
            access_reg    <= access_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
        end
    end

endmodule

FILE: sv/tlcd_queue.sv
// Short pixel queue between the decode front end and the index back end.
module tlcd_queue #(
    parameter int DEPTH = tlcd_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  tlcd_pkg::tlcd_pix_t    push_entry,
    input  logic                   pop,
    output tlcd_pkg::tlcd_pix_t    head,
    output tlcd_pkg::tlcd_qstat_t  qstat
);
    import tlcd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlcd_pix_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign qstat.full  = count_reg == CNT_W'(DEPTH);
    assign qstat.empty = count_reg == '0;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/tlcd_back.sv
// Back end: rotation, frame-store index multiply and output register.
module tlcd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlcd_pkg::tlcd_cfg_t    cfg,
    input  tlcd_pkg::tlcd_qstat_t  qstat,
    input  tlcd_pkg::tlcd_pix_t    head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [19:0]            m_pixel_index,
    output logic [7:0]             m_red,
    output logic [7:0]             m_green,
    output logic [7:0]             m_blue
);
    import tlcd_pkg::*;

    // Stage 1: index = mul_a * mul_b + addend
    logic        s1_valid_reg;
    logic [10:0] mul_a_reg, mul_b_reg, addend_reg;
    logic [7:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [10:0] mul_a_next, mul_b_next, addend_next;

    logic        m_valid_reg;
    logic [19:0] index_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;

    logic        out_free, s1_free;
    logic [10:0] w, h;
    logic [21:0] product;
    logic [22:0] sum;

    assign w        = cfg.panel_width;
    assign h        = cfg.panel_height;
    assign out_free = !m_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = s1_free && !qstat.empty;

    always_comb begin
        case (cfg.rotation)
            ROT_0: begin
                mul_a_next  = w;
                mul_b_next  = h - 11'd1 - head.y;
                addend_next = head.x;
            end
            ROT_90: begin
                mul_a_next  = h;
                mul_b_next  = head.x;
                addend_next = head.y;
            end
            ROT_180: begin
                mul_a_next  = w;
                mul_b_next  = head.y;
                addend_next = w - 11'd1 - head.x;
            end
            ROT_270: begin
                mul_a_next  = h;
                mul_b_next  = w - 11'd1 - head.x;
                addend_next = h - 11'd1 - head.y;
            end
            default: begin
                mul_a_next  = w;
                mul_b_next  = head.y;
                addend_next = head.x;
            end
        endcase
    end

    assign product = {11'b0, mul_a_reg} * {11'b0, mul_b_reg};
    assign sum     = {1'b0, product} + {12'b0, addend_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= !qstat.empty;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            mul_a_reg    <= mul_a_next;
            mul_b_reg    <= mul_b_next;
            addend_reg   <= addend_next;
            s1_red_reg   <= head.red;
            s1_green_reg <= head.green;
            s1_blue_reg  <= head.blue;
        end
        if (s1_valid_reg && out_free) begin
            index_reg <= sum[19:0];
            red_reg   <= s1_red_reg;
            green_reg <= s1_green_reg;
            blue_reg  <= s1_blue_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = index_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;

endmodule

FILE: sv/tft_lcd_bus_controller_core.sv
// Top level of the TFT LCD bus controller: configuration registers, front end, queue, back end.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_cmd, s_bus_data
//   m_        out        m_valid / m_ready   m_pixel_index, m_red, m_green, m_blue
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One bus word is taken per cycle while s_ready is high; a pixel result passes through the queue
// write, the index multiply stage and the output register before it shows on m_.
// Reset: format packed16, rotation 0, panel 240x320, window covers the panel, queue empty.
// A stalled m_ fills the output register, the multiply stage and the QUEUE_DEPTH-entry queue,
// after which s_ready drops. cfg_ready is always high.
module tft_lcd_bus_controller_core #(
    parameter int QUEUE_DEPTH = tlcd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [17:0] s_bus_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [19:0] m_pixel_index,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import tlcd_pkg::*;

    logic [2:0]  pixel_format_reg;
    logic [1:0]  rotation_reg;
    logic [10:0] panel_width_reg;
    logic [10:0] panel_height_reg;

    tlcd_cfg_t   cfg;
    tlcd_qstat_t qstat;
    tlcd_pix_t   push_entry, head;
    logic        q_push, q_pop;

    assign cfg_ready        = 1'b1;
    assign cfg.pixel_format = pixel_format_reg;
    assign cfg.rotation     = rotation_reg;
    assign cfg.panel_width  = panel_width_reg;
    assign cfg.panel_height = panel_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= FMT_PACKED16;
            rotation_reg     <= ROT_0;
            panel_width_reg  <= RESET_WIDTH;
            panel_height_reg <= RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[2:0];
                CFG_ROTATION:     rotation_reg     <= cfg_data[1:0];
                CFG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                CFG_PANEL_HEIGHT: panel_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tlcd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_bus_data (s_bus_data),
        .qstat      (qstat),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    tlcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .qstat      (qstat)
    );

    tlcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .qstat         (qstat),
        .head          (head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !q_push)
        else $error("pixel pushed into a full queue");

    a_cmd_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd) |-> !q_push)
        else $error("command word produced a pixel");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.empty |-> !q_pop)
        else $error("pop from an empty queue");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
